### rtl/cds_pkg.sv
// Shared types, constants and calendar helper functions for the date stepper.
package cds_pkg;

	localparam int YearW  = 14;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int CountW = 16;
	localparam int ModW   = 7;
	localparam int DdW    = 18;

	localparam logic [1:0] ReqLoad = 2'd0;
	localparam logic [1:0] ReqAdd  = 2'd1;
	localparam logic [1:0] ReqSub  = 2'd2;
	localparam logic [1:0] ReqCmp  = 2'd3;

	localparam logic [YearW-1:0]  YearMin    = 14'd1;
	localparam logic [YearW-1:0]  YearMax    = 14'd9999;
	localparam logic [ModW-1:0]   YearMinMod = 7'd1;
	localparam logic [ModW-1:0]   YearMaxMod = 7'd99;
	localparam logic [ModW-1:0]   ModLast    = 7'd99;
	localparam logic [YearW-1:0]  Century    = 14'd100;
	localparam logic [MonthW-1:0] MonthFirst = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
	localparam logic [MonthW-1:0] MonthLast  = 4'd12;
	localparam logic [DayW-1:0]   DayFirst   = 5'd1;
	localparam logic [DayW-1:0]   DayLast    = 5'd31;
	localparam logic [DayW-1:0]   LenShort   = 5'd30;
	localparam logic [DayW-1:0]   LenFeb     = 5'd28;
	localparam logic [DayW-1:0]   LenFebLeap = 5'd29;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [YearW-1:0]  in_year;
		logic [MonthW-1:0] in_month;
		logic [DayW-1:0]   in_day;
		logic [CountW-1:0] day_count;
	} req_t;

	typedef struct packed {
		logic [YearW-1:0]  out_year;
		logic [MonthW-1:0] out_month;
		logic [DayW-1:0]   out_day;
		logic              is_greater;
		logic              is_equal;
		logic              range_error;
	} rsp_t;

	// year and month with the year's remainder mod 100 kept alongside
	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [ModW-1:0]   mod100;
		logic [MonthW-1:0] month;
	} cal_t;

	typedef struct packed {
		logic done;
		logic sat;
	} step_st_t;

	// y%4 is y[1:0]; for a century year, y%400==0 reduces to y[3:0]==0
	function automatic logic is_leap(logic [YearW-1:0] y, logic [ModW-1:0] m100);
		return (y[1:0] == 2'd0) && ((m100 != '0) || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m, logic leap);
		logic [DayW-1:0] len;
		len = DayLast;
		if (m == MonthFeb)
			len = leap ? LenFebLeap : LenFeb;
		else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
			len = LenShort;
		return len;
	endfunction

endpackage

### rtl/cds_step_unit.sv
// Shared month step unit: one carry or borrow across a month boundary per use.
module cds_step_unit (
	input  logic                         sub,
	input  cds_pkg::cal_t                cal,
	input  logic signed [cds_pkg::DdW-1:0] dd,
	output cds_pkg::cal_t                cal_nxt,
	output logic signed [cds_pkg::DdW-1:0] dd_nxt,
	output cds_pkg::step_st_t            st
);
	import cds_pkg::*;

	logic [DayW-1:0]   len_cur;
	logic [DayW-1:0]   len_prev;
	logic [ModW-1:0]   mod_up;
	logic [ModW-1:0]   mod_dn;
	cal_t              prev;
	logic signed [DdW-1:0] len_cur_s;
	logic signed [DdW-1:0] len_prev_s;

	always_comb begin
		len_cur   = month_len(cal.month, is_leap(cal.year, cal.mod100));
		mod_up    = (cal.mod100 == ModLast) ? '0 : cal.mod100 + 7'd1;
		mod_dn    = (cal.mod100 == '0) ? ModLast : cal.mod100 - 7'd1;
		if (cal.month == MonthFirst) begin
			prev.month  = MonthLast;
			prev.year   = cal.year - 14'd1;
			prev.mod100 = mod_dn;
		end else begin
			prev.month  = cal.month - 4'd1;
			prev.year   = cal.year;
			prev.mod100 = cal.mod100;
		end
		len_prev   = month_len(prev.month, is_leap(prev.year, prev.mod100));
		len_cur_s  = $signed({{(DdW-DayW){1'b0}}, len_cur});
		len_prev_s = $signed({{(DdW-DayW){1'b0}}, len_prev});

		cal_nxt = cal;
		dd_nxt  = dd;
		st      = '0;
		if (!sub) begin
			st.done = (dd <= len_cur_s);
			if (!st.done) begin
				dd_nxt = dd - len_cur_s;
				if (cal.month == MonthLast) begin
					if (cal.year == YearMax) begin
						st.sat          = 1'b1;
						cal_nxt.year    = YearMax;
						cal_nxt.mod100  = YearMaxMod;
						cal_nxt.month   = MonthLast;
						dd_nxt          = $signed({{(DdW-DayW){1'b0}}, DayLast});
					end else begin
						cal_nxt.year    = cal.year + 14'd1;
						cal_nxt.mod100  = mod_up;
						cal_nxt.month   = MonthFirst;
					end
				end else begin
					cal_nxt.month = cal.month + 4'd1;
				end
			end
		end else begin
			st.done = (dd > 0);
			if (!st.done) begin
				if (cal.month == MonthFirst && cal.year == YearMin) begin
					st.sat         = 1'b1;
					cal_nxt.year   = YearMin;
					cal_nxt.mod100 = YearMinMod;
					cal_nxt.month  = MonthFirst;
					dd_nxt         = $signed({{(DdW-DayW){1'b0}}, DayFirst});
				end else begin
					cal_nxt = prev;
					dd_nxt  = dd + len_prev_s;
				end
			end
		end
	end

endmodule

### rtl/calendar_date_day_stepper.sv
// Top level of the calendar date stepper: request sequencer, date state, result register.
//
// Holds one Gregorian date (reset value 0001-01-01) and serves one request item
// at a time on the req channel; each request yields one result item on rsp.
// Request kinds: load a date (clamped to a valid date), add or subtract a day
// count, or compare the stored date with the given one.
// Work per item, from acceptance to the result register:
//   compare:       the result is registered as the item is accepted
//   load:          year mod 100 is formed by restoring shift-subtract steps,
//                  then the day is clamped
//   add, subtract: one step per month boundary crossed; the shared
//                  month step unit handles one boundary a cycle.
// req_ready is low while an item is being worked on, and also while a finished
// result waits in the rsp register with rsp_ready low; the next item is taken
// only once that result leaves, so a waiting result is never overwritten.
// Reset clears the date to 0001-01-01 and drops rsp_valid.
module calendar_date_day_stepper (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cds_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cds_pkg::rsp_t rsp
);
	import cds_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StMod  = 2'd1;
	localparam logic [1:0] StDay  = 2'd2;
	localparam logic [1:0] StStep = 2'd3;

	logic [1:0]            state_q;
	cal_t                  cal_q;
	logic [DayW-1:0]       cur_day_q;
	logic signed [DdW-1:0] dd_q;
	logic                  sub_q;
	logic                  err_q;
	logic [YearW-1:0]      rem_q;
	logic [2:0]            k_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	cal_t                  cal_nxt;
	logic signed [DdW-1:0] dd_nxt;
	step_st_t              step_st;

	logic                  accept;
	logic                  out_free;
	logic                  rsp_set;
	logic [YearW-1:0]      rem_sub;
	logic [YearW-1:0]      rem_nxt;
	logic [YearW-1:0]      ld_year;
	logic [MonthW-1:0]     ld_month;
	logic                  ld_err;
	logic [DayW-1:0]       ld_len;
	logic [DayW-1:0]       ld_day;
	logic                  ld_day_err;
	logic                  cmp_gt;
	logic                  cmp_eq;

	cds_step_unit u_step (
		.sub     (sub_q),
		.cal     (cal_q),
		.dd      (dd_q),
		.cal_nxt (cal_nxt),
		.dd_nxt  (dd_nxt),
		.st      (step_st)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == StIdle) && out_free;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a result item is written this cycle
	assign rsp_set = (accept && (req.req_type == ReqCmp))
		|| ((state_q == StDay) && out_free)
		|| ((state_q == StStep) && step_st.done && out_free);

	always_comb begin
		// load clamping of year and month
		ld_err   = 1'b0;
		ld_year  = req.in_year;
		ld_month = req.in_month;
		if (req.in_year < YearMin) begin
			ld_year = YearMin;
			ld_err  = 1'b1;
		end
		if (req.in_year > YearMax) begin
			ld_year = YearMax;
			ld_err  = 1'b1;
		end
		if (req.in_month < MonthFirst) begin
			ld_month = MonthFirst;
			ld_err   = 1'b1;
		end
		if (req.in_month > MonthLast) begin
			ld_month = MonthLast;
			ld_err   = 1'b1;
		end

		// one restoring step of year mod 100: subtract 100 << k when it fits
		rem_sub = Century << k_q;
		rem_nxt = (rem_q >= rem_sub) ? rem_q - rem_sub : rem_q;

		// day clamp once the year's leap status is known
		ld_len     = month_len(cal_q.month, is_leap(cal_q.year, cal_q.mod100));
		ld_day     = dd_q[DayW-1:0];
		ld_day_err = 1'b0;
		if (ld_day < DayFirst) begin
			ld_day     = DayFirst;
			ld_day_err = 1'b1;
		end
		if (ld_day > ld_len) begin
			ld_day     = ld_len;
			ld_day_err = 1'b1;
		end

		cmp_gt = 1'b0;
		cmp_eq = 1'b0;
		if (cal_q.year != req.in_year)
			cmp_gt = cal_q.year > req.in_year;
		else if (cal_q.month != req.in_month)
			cmp_gt = cal_q.month > req.in_month;
		else if (cur_day_q != req.in_day)
			cmp_gt = cur_day_q > req.in_day;
		else
			cmp_eq = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= StIdle;
			cal_q.year   <= YearMin;
			cal_q.mod100 <= YearMinMod;
			cal_q.month  <= MonthFirst;
			cur_day_q    <= DayFirst;
			rsp_valid_q  <= 1'b0;
			err_q        <= 1'b0;
			sub_q        <= 1'b0;
			k_q          <= '0;
		end else begin
			if (rsp_set)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (accept) begin
						case (req.req_type)
							ReqLoad: begin
								cal_q.year  <= ld_year;
								cal_q.month <= ld_month;
								err_q       <= ld_err;
								k_q         <= 3'd6;
								state_q     <= StMod;
							end
							ReqAdd, ReqSub: begin
								sub_q   <= (req.req_type == ReqSub);
								err_q   <= 1'b0;
								state_q <= StStep;
							end
							default: ;
						endcase
					end
				end
				StMod: begin
					k_q <= k_q - 3'd1;
					if (k_q == '0) begin
						cal_q.mod100 <= rem_nxt[ModW-1:0];
						state_q      <= StDay;
					end
				end
				StDay: begin
					if (out_free) begin
						cur_day_q <= ld_day;
						err_q     <= err_q | ld_day_err;
						state_q   <= StIdle;
					end
				end
				StStep: begin
					if (step_st.done) begin
						if (out_free) begin
							cur_day_q <= dd_q[DayW-1:0];
							state_q   <= StIdle;
						end
					end else begin
						cal_q <= cal_nxt;
						err_q <= err_q | step_st.sat;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				if (accept) begin
					case (req.req_type)
						ReqLoad: begin
							rem_q <= ld_year;
							dd_q  <= $signed({{(DdW-DayW){1'b0}}, req.in_day});
						end
						ReqAdd: begin
							dd_q <= $signed({{(DdW-DayW){1'b0}}, cur_day_q})
								+ $signed({{(DdW-CountW){1'b0}}, req.day_count});
						end
						ReqSub: begin
							dd_q <= $signed({{(DdW-DayW){1'b0}}, cur_day_q})
								- $signed({{(DdW-CountW){1'b0}}, req.day_count});
						end
						default: begin
							rsp_q.out_year    <= cal_q.year;
							rsp_q.out_month   <= cal_q.month;
							rsp_q.out_day     <= cur_day_q;
							rsp_q.is_greater  <= cmp_gt;
							rsp_q.is_equal    <= cmp_eq;
							rsp_q.range_error <= 1'b0;
						end
					endcase
				end
			end
			StMod: begin
				rem_q <= rem_nxt;
			end
			StDay: begin
				if (out_free) begin
					rsp_q.out_year    <= cal_q.year;
					rsp_q.out_month   <= cal_q.month;
					rsp_q.out_day     <= ld_day;
					rsp_q.is_greater  <= 1'b0;
					rsp_q.is_equal    <= 1'b0;
					rsp_q.range_error <= err_q | ld_day_err;
				end
			end
			StStep: begin
				if (step_st.done) begin
					if (out_free) begin
						rsp_q.out_year    <= cal_q.year;
						rsp_q.out_month   <= cal_q.month;
						rsp_q.out_day     <= dd_q[DayW-1:0];
						rsp_q.is_greater  <= 1'b0;
						rsp_q.is_equal    <= 1'b0;
						rsp_q.range_error <= err_q;
					end
				end else begin
					dd_q <= dd_nxt;
				end
			end
			default: begin
				dd_q <= dd_q;
			end
		endcase
	end

endmodule

### rtl/cds_checker.sv
// Port-level checks for the calendar date stepper, bound to the top level.
module cds_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input cds_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input cds_pkg::rsp_t rsp
);
	import cds_pkg::*;

	// a waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// a valid result's date lies within the year, month and day ranges
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.out_year >= YearMin && rsp.out_year <= YearMax
			&& rsp.out_month >= MonthFirst && rsp.out_month <= MonthLast
			&& rsp.out_day >= DayFirst && rsp.out_day <= DayLast)
		else $error("result date out of range");

	// compare flags are exclusive and never come with a range error
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.is_greater && rsp.is_equal)
			&& !((rsp.is_greater || rsp.is_equal) && rsp.range_error))
		else $error("inconsistent result flags");

	// a compare item's result is registered in the cycle it is accepted and carries no range error
	a_cmp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == ReqCmp |=> rsp_valid && !rsp.range_error)
		else $error("compare result missing");

endmodule

bind calendar_date_day_stepper cds_checker u_cds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
